// ----- rtl/core/dmc_pkg.sv -----
// Shared constants and types for the direct-mapped write-back cache core.
// No dependencies.
package dmc_pkg;

    localparam int DMC_NUM_LINES      = 128;
    localparam int DMC_WORDS_PER_LINE = 16;
    localparam int DMC_MEM_WORDS      = 4194304;

    localparam int DMC_ADDR_W  = 24;              // byte address
    localparam int DMC_WADDR_W = DMC_ADDR_W - 2;  // word address
    localparam int DMC_DATA_W  = 32;
    localparam int DMC_CNT_W   = 32;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Counter update strobes, sequencer -> statistics block
    typedef struct packed {
        logic count_hit;
        logic count_miss;
    } t_stat_ctl;

endpackage

// ----- rtl/core/dmc_req_if.sv -----
// Request channel: valid/ready plus one cache access.
// Depends on dmc_pkg.
interface dmc_req_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [dmc_pkg::DMC_ADDR_W-1:0]    address;
    logic [dmc_pkg::DMC_DATA_W-1:0]    write_data;

    modport source (output valid, command, address, write_data, input ready);
    modport sink   (input valid, command, address, write_data, output ready);
endinterface

// ----- rtl/core/dmc_rsp_if.sv -----
// Response channel: valid/ready plus read data, hit flag and counts.
// Depends on dmc_pkg.
interface dmc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [dmc_pkg::DMC_DATA_W-1:0]    read_data;
    logic                              hit;
    logic [dmc_pkg::DMC_CNT_W-1:0]     hit_count;
    logic [dmc_pkg::DMC_CNT_W-1:0]     miss_count;

    modport source (output valid, read_data, hit, hit_count, miss_count, input ready);
    modport sink   (input valid, read_data, hit, hit_count, miss_count, output ready);
endinterface

// ----- rtl/core/dmc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dmc_stats.sv -----
// Running hit and miss counters; presents the post-update values.
// Depends on dmc_pkg.
module dmc_stats (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dmc_pkg::t_stat_ctl             i_ctl,
    output logic [dmc_pkg::DMC_CNT_W-1:0]  o_hits_next,
    output logic [dmc_pkg::DMC_CNT_W-1:0]  o_misses_next
);

    logic [dmc_pkg::DMC_CNT_W-1:0] r_hits;
    logic [dmc_pkg::DMC_CNT_W-1:0] r_misses;
    logic [dmc_pkg::DMC_CNT_W-1:0] n_hits;
    logic [dmc_pkg::DMC_CNT_W-1:0] n_misses;

    // wraps naturally at 2^32
    assign n_hits   = r_hits + dmc_pkg::DMC_CNT_W'(i_ctl.count_hit);
    assign n_misses = r_misses + dmc_pkg::DMC_CNT_W'(i_ctl.count_miss);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
        end else begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
        end
    end

    assign o_hits_next   = n_hits;
    assign o_misses_next = n_misses;

endmodule

// ----- rtl/core/direct_mapped_writeback_cache_core.sv -----
// Top level of the direct-mapped write-back, write-allocate cache with its backing store.
// Depends on dmc_pkg, dmc_req_if, dmc_rsp_if, dmc_ram and dmc_stats.
//
//  channel  | dir | beat contents                                 | handshake
//  ---------+-----+-----------------------------------------------+-------------------
//  i_req    | in  | command, address, write_data                  | valid & ready
//  o_rsp    | out | read_data, hit, hit_count, miss_count          | valid & ready
//
// Sequence: a hit is accepted, then its tag and data are looked up. A clean miss
//   walks the line with one backing-store read per word of the line fill;
//   a dirty victim first adds a write-back walk that reads the line from the data
//   RAM, one word per cycle. One beat is in flight at a time.
// Reset: synchronous, active low. After reset a clearing pass over
//   max(MEM_WORDS, NUM_LINES) addresses (4194304 by default) zeroes the backing
//   store and the tag RAM; i_req.ready stays low until it ends.
// Stalls: the response sits in an output register; a held response only blocks
//   the end of the following access, not its acceptance or its line traffic.
// NUM_LINES, WORDS_PER_LINE and MEM_WORDS are powers of two.
module direct_mapped_writeback_cache_core #(
    parameter int NUM_LINES      = dmc_pkg::DMC_NUM_LINES,
    parameter int WORDS_PER_LINE = dmc_pkg::DMC_WORDS_PER_LINE,
    parameter int MEM_WORDS      = dmc_pkg::DMC_MEM_WORDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmc_req_if.sink    i_req,
    dmc_rsp_if.source  o_rsp
);

    // ---------------------------------------------------------------
    // Address split: word address = {tag, index, offset}
    // ---------------------------------------------------------------
    localparam int WA_W  = dmc_pkg::DMC_WADDR_W;
    localparam int DW    = dmc_pkg::DMC_DATA_W;
    localparam int CW    = dmc_pkg::DMC_CNT_W;
    localparam int WB    = $clog2(WORDS_PER_LINE);
    localparam int IB    = $clog2(NUM_LINES);
    localparam int MB    = $clog2(MEM_WORDS);
    localparam int TAG_W = WA_W - WB - IB;
    localparam int DA_W  = IB + WB;
    localparam int TE_W  = TAG_W + 2;                    // {valid, dirty, tag}
    localparam int CLR_N = (MEM_WORDS > NUM_LINES) ? MEM_WORDS : NUM_LINES;
    localparam int CLR_W = $clog2(CLR_N);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;   // post-reset sweep
    localparam logic [2:0] S_IDLE  = 3'd1;   // waiting for a request
    localparam logic [2:0] S_LOOK  = 3'd2;   // tag and data read back
    localparam logic [2:0] S_WBACK = 3'd3;   // dirty victim -> backing store
    localparam logic [2:0] S_FILL  = 3'd4;   // backing store -> line
    localparam logic [2:0] S_RESP  = 3'd5;   // miss result waits for output

    logic [2:0]       r_state, n_state;
    logic [WB:0]      r_cnt, n_cnt;          // line walk, 0..WORDS_PER_LINE
    logic [CLR_W-1:0] r_clr;

    // request held for the duration of the access
    logic             r_cmd;
    logic [WA_W-1:0]  r_word;
    logic [DW-1:0]    r_wdata;
    logic [TAG_W-1:0] r_vtag;                // victim tag for write-back
    logic [DW-1:0]    r_res;                 // word picked up during fill

    // output register
    logic             r_out_valid;
    logic [DW-1:0]    r_out_data;
    logic             r_out_hit;
    logic [CW-1:0]    r_out_hits;
    logic [CW-1:0]    r_out_misses;

    // ---------------------------------------------------------------
    // Field extraction
    // ---------------------------------------------------------------
    logic [WA_W-1:0]  in_word;
    logic [WB-1:0]    in_off, r_off, cnt_lo, cnt_prev;
    logic [IB-1:0]    in_idx, r_idx;
    logic [TAG_W-1:0] r_tag;

    assign in_word  = i_req.address[dmc_pkg::DMC_ADDR_W-1:2];
    assign in_off   = in_word[WB-1:0];
    assign in_idx   = in_word[DA_W-1:WB];
    assign r_off    = r_word[WB-1:0];
    assign r_idx    = r_word[DA_W-1:WB];
    assign r_tag    = r_word[WA_W-1:DA_W];
    assign cnt_lo   = r_cnt[WB-1:0];
    assign cnt_prev = cnt_lo - WB'(1);       // word whose read data lands now

    // backing-store slots wrap modulo MEM_WORDS: keep the low bits
    logic [WA_W-1:0] victim_word, fill_word;
    assign victim_word = {r_vtag, r_idx, cnt_prev};
    assign fill_word   = {r_word[WA_W-1:WB], cnt_lo};

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic            tag_we;
    logic [IB-1:0]   tag_waddr, tag_raddr;
    logic [TE_W-1:0] tag_wdata, tag_rdata;

    logic            dat_we;
    logic [DA_W-1:0] dat_waddr, dat_raddr;
    logic [DW-1:0]   dat_wdata, dat_rdata;

    logic            bk_we;
    logic [MB-1:0]   bk_waddr, bk_raddr;
    logic [DW-1:0]   bk_wdata, bk_rdata;

    dmc_ram #(.WIDTH(TE_W), .DEPTH(NUM_LINES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    dmc_ram #(.WIDTH(DW), .DEPTH(NUM_LINES * WORDS_PER_LINE)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (dat_waddr),
        .i_wdata (dat_wdata),
        .i_raddr (dat_raddr),
        .o_rdata (dat_rdata)
    );

    dmc_ram #(.WIDTH(DW), .DEPTH(MEM_WORDS)) u_backing_ram (
        .i_clk   (i_clk),
        .i_we    (bk_we),
        .i_waddr (bk_waddr),
        .i_wdata (bk_wdata),
        .i_raddr (bk_raddr),
        .o_rdata (bk_rdata)
    );

    // ---------------------------------------------------------------
    // Statistics
    // ---------------------------------------------------------------
    dmc_pkg::t_stat_ctl stat_ctl;
    logic [CW-1:0]      hits_next, misses_next;

    dmc_stats u_stats (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (stat_ctl),
        .o_hits_next   (hits_next),
        .o_misses_next (misses_next)
    );

    // ---------------------------------------------------------------
    // Lookup decode
    // ---------------------------------------------------------------
    logic             t_valid, t_dirty, look_hit, out_free, is_write;
    logic             walk_end, clr_tag_ok, clr_bk_ok, fill_pick;
    logic [TAG_W-1:0] t_tag;
    logic [DW-1:0]    fill_data;

    assign t_valid   = tag_rdata[TE_W-1];
    assign t_dirty   = tag_rdata[TE_W-2];
    assign t_tag     = tag_rdata[TAG_W-1:0];
    assign look_hit  = t_valid && (t_tag == r_tag);
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign is_write  = (r_cmd == dmc_pkg::CMD_WRITE);
    assign walk_end  = (r_cnt == (WB+1)'(WORDS_PER_LINE));
    assign fill_pick = (r_cnt != '0) && (cnt_prev == r_off);
    // write merges into the line as it is filled
    assign fill_data = (is_write && cnt_prev == r_off) ? r_wdata : bk_rdata;

    assign clr_tag_ok = {1'b0, r_clr} < (CLR_W+1)'(NUM_LINES);
    assign clr_bk_ok  = {1'b0, r_clr} < (CLR_W+1)'(MEM_WORDS);

    assign i_req.ready = (r_state == S_IDLE);

    logic accept, load_hit, load_miss;
    assign accept    = i_req.valid && (r_state == S_IDLE);
    assign load_hit  = (r_state == S_LOOK) && look_hit && out_free;
    assign load_miss = (r_state == S_RESP) && out_free;

    assign stat_ctl.count_hit  = load_hit;
    assign stat_ctl.count_miss = load_miss;

    // ---------------------------------------------------------------
    // Sequencer and memory port control
    // ---------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;

        tag_we    = 1'b0;
        tag_waddr = r_idx;
        tag_wdata = {1'b1, r_cmd, r_tag};
        tag_raddr = r_idx;

        dat_we    = 1'b0;
        dat_waddr = {r_idx, r_off};
        dat_wdata = r_wdata;
        dat_raddr = {r_idx, r_off};

        bk_we     = 1'b0;
        bk_waddr  = victim_word[MB-1:0];
        bk_wdata  = dat_rdata;
        bk_raddr  = fill_word[MB-1:0];

        case (r_state)
            S_CLEAR: begin
                tag_we    = clr_tag_ok;
                tag_waddr = r_clr[IB-1:0];
                tag_wdata = '0;
                bk_we     = clr_bk_ok;
                bk_waddr  = r_clr[MB-1:0];
                bk_wdata  = '0;
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // reads launched off the incoming beat
                tag_raddr = in_idx;
                dat_raddr = {in_idx, in_off};
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_cnt = '0;
                if (look_hit) begin
                    if (out_free) begin
                        tag_we  = is_write;      // set dirty
                        dat_we  = is_write;
                        n_state = S_IDLE;
                    end
                end else if (t_valid && t_dirty) begin
                    n_state = S_WBACK;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_WBACK: begin
                dat_raddr = {r_idx, cnt_lo};
                bk_we     = (r_cnt != '0);
                if (walk_end) begin
                    n_cnt   = '0;
                    n_state = S_FILL;
                end else begin
                    n_cnt = r_cnt + (WB+1)'(1);
                end
            end
            S_FILL: begin
                dat_we    = (r_cnt != '0);
                dat_waddr = {r_idx, cnt_prev};
                dat_wdata = fill_data;
                if (walk_end) begin
                    tag_we  = 1'b1;              // valid, dirty on write
                    n_state = S_RESP;
                end else begin
                    n_cnt = r_cnt + (WB+1)'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (load_hit || load_miss) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_req.command;
            r_word  <= in_word;
            r_wdata <= i_req.write_data;
        end
        if (r_state == S_LOOK) begin
            r_vtag <= t_tag;
        end
        if (r_state == S_FILL && fill_pick) begin
            r_res <= fill_data;
        end
        if (load_hit) begin
            r_out_data   <= is_write ? r_wdata : dat_rdata;
            r_out_hit    <= 1'b1;
            r_out_hits   <= hits_next;
            r_out_misses <= misses_next;
        end else if (load_miss) begin
            r_out_data   <= r_res;
            r_out_hit    <= 1'b0;
            r_out_hits   <= hits_next;
            r_out_misses <= misses_next;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_data  = r_out_data;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.hit_count  = r_out_hits;
    assign o_rsp.miss_count = r_out_misses;

endmodule
